// ===== hw/rtl/bsm_pkg.sv =====
// Package with operation codes, register indexes and constants of the bank switch mapper.
`timescale 1ns / 1ps

package bsm_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_TICK  = 2'd1,
      OP_PROG  = 2'd2,
      OP_CHAR  = 2'd3
   } op_type;

   localparam int CHAR_BANKS    = 8;
   localparam int PROG_BANKS    = 4;
   localparam int BANK_W        = 8;
   localparam int COUNT_W       = 16;
   localparam int MAPPED_W      = 21;
   localparam int PROG_OFFSET_W = 13;
   localparam int CHAR_OFFSET_W = 10;

   localparam logic [3:0] REG_MIRROR   = 4'd12;
   localparam logic [3:0] REG_STOP     = 4'd13;
   localparam logic [3:0] REG_COUNT_LO = 4'd14;
   localparam logic [3:0] REG_COUNT_HI = 4'd15;

   localparam logic [COUNT_W-1:0] COUNT_TOP     = 16'hFFFF;
   localparam logic [BANK_W-1:0]  PROG_FIXED_OR = 8'h10;

   localparam logic [1:0] PROG_WIN_FIRST = 2'd0;
   localparam logic [1:0] PROG_WIN_LAST  = 2'd3;

endpackage

// ===== hw/rtl/bank_switch_mapper_with_cycle_irq_unit.sv =====
// Cartridge mapper with bank registers, address translation and a cycle interrupt counter.
`timescale 1ns / 1ps

// Usage
// The req_ channel carries one item per transfer: a register write, a CPU cycle
// tick, a program address translation or a character address translation.
// The rsp_ channel returns exactly one result per item: the mapped ROM offset
// (zero for writes and ticks), the interrupt line and the mirroring bit as they
// stand after the item.
// The result is registered: an item accepted at one edge has its result on rsp_
// after that edge. Throughput is one item per cycle while the receiver takes each
// result; the bank registers and the counter are updated by shallow logic in the
// same cycle that the item is accepted. A single output register holds the result.
// While it is full and the receiver stalls, req_ready is low; it returns high in
// the cycle the result is taken, so a new item can enter alongside that transfer.
// Reset clears all banks, the mirroring bit, the counter, its enable and the
// interrupt line, and empties the output register.
module bank_switch_mapper_with_cycle_irq_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [15:0]                  req_address,
   input  logic [7:0]                   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bsm_pkg::MAPPED_W-1:0] rsp_mapped_address,
   output logic                         rsp_irq_line,
   output logic                         rsp_mirroring_horizontal
);

   logic [bsm_pkg::BANK_W-1:0]  char_banks_ff [bsm_pkg::CHAR_BANKS];
   logic [bsm_pkg::BANK_W-1:0]  char_banks_in [bsm_pkg::CHAR_BANKS];
   logic [bsm_pkg::BANK_W-1:0]  prog_banks_ff [bsm_pkg::PROG_BANKS];
   logic [bsm_pkg::BANK_W-1:0]  prog_banks_in [bsm_pkg::PROG_BANKS];
   logic                        mirror_ff, mirror_in;
   logic                        enable_ff, enable_in;
   logic [bsm_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        irq_ff, irq_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bsm_pkg::MAPPED_W-1:0] mapped_ff, mapped_in;
   logic                        accept;
   bsm_pkg::op_type             op;
   logic [3:0]                  sel;
   logic [1:0]                  prog_win;
   logic [2:0]                  char_win;
   logic [bsm_pkg::BANK_W-1:0]  prog_bank;
   logic [bsm_pkg::COUNT_W-1:0] count_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = bsm_pkg::op_type'(req_operation);
   assign sel       = req_address[3:0];
   assign prog_win  = req_address[14:13];
   assign char_win  = req_address[12:10];
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      prog_bank = prog_banks_ff[prog_win];
      if (prog_win == bsm_pkg::PROG_WIN_FIRST || prog_win == bsm_pkg::PROG_WIN_LAST) begin
         prog_bank = prog_bank | bsm_pkg::PROG_FIXED_OR;
      end
   end

   always_comb begin
      char_banks_in = char_banks_ff;
      prog_banks_in = prog_banks_ff;
      mirror_in     = mirror_ff;
      enable_in     = enable_ff;
      count_in      = count_ff;
      irq_in        = irq_ff;
      mapped_in     = '0;
      if (accept) begin
         unique case (op)
            bsm_pkg::OP_WRITE: begin
               priority if (!sel[3]) begin
                  // The first four character banks take their low bit from the index.
                  if (sel[2]) begin
                     char_banks_in[sel[2:0]] = req_value;
                  end else begin
                     char_banks_in[sel[2:0]] = {req_value[7:1], sel[0]};
                  end
               end else if (!sel[2]) begin
                  prog_banks_in[sel[1:0]] = req_value;
               end else if (sel == bsm_pkg::REG_MIRROR) begin
                  mirror_in = req_value[0];
               end else if (sel == bsm_pkg::REG_STOP) begin
                  enable_in = 1'b0;
                  count_in  = '0;
                  irq_in    = 1'b0;
               end else if (sel == bsm_pkg::REG_COUNT_LO) begin
                  count_in = {count_ff[15:8], req_value};
               end else begin
                  count_in  = {req_value, count_ff[7:0]};
                  enable_in = 1'b1;
               end
            end
            bsm_pkg::OP_TICK: begin
               // The counter saturates; only an enabled tick that reaches the top raises the line.
               if (count_ff != bsm_pkg::COUNT_TOP) begin
                  count_in = count_inc;
                  if (count_inc == bsm_pkg::COUNT_TOP && enable_ff) begin
                     irq_in = 1'b1;
                  end
               end
            end
            bsm_pkg::OP_PROG: begin
               mapped_in = {prog_bank, req_address[12:0]};
            end
            bsm_pkg::OP_CHAR: begin
               mapped_in = {3'd0, char_banks_ff[char_win], req_address[9:0]};
            end
            default: begin
               mapped_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bsm_pkg::CHAR_BANKS; i++) begin
            char_banks_ff[i] <= '0;
         end
         for (int i = 0; i < bsm_pkg::PROG_BANKS; i++) begin
            prog_banks_ff[i] <= '0;
         end
         mirror_ff    <= 1'b0;
         enable_ff    <= 1'b0;
         count_ff     <= '0;
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         char_banks_ff <= char_banks_in;
         prog_banks_ff <= prog_banks_in;
         mirror_ff     <= mirror_in;
         enable_ff     <= enable_in;
         count_ff      <= count_in;
         irq_ff        <= irq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mapped_ff <= mapped_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_mapped_address       = mapped_ff;
   assign rsp_irq_line             = irq_ff;
   assign rsp_mirroring_horizontal = mirror_ff;

`ifndef NO_ASSERTIONS
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && op == bsm_pkg::OP_WRITE && sel == bsm_pkg::REG_STOP)
      |=> (!irq_ff && count_ff == '0 && !enable_ff))
      else $error("stop write did not clear the counter");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (accept && op == bsm_pkg::OP_TICK && count_ff == bsm_pkg::COUNT_TOP)
      |=> (count_ff == bsm_pkg::COUNT_TOP))
      else $error("counter moved past its top value");

   a_irq_rise_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_ff) |-> $past(accept && op == bsm_pkg::OP_TICK && enable_ff))
      else $error("interrupt raised without an enabled tick");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled while the output register is empty");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !irq_ff && !mirror_ff))
      else $error("state not cleared by reset");
`endif

endmodule
